// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes of the sorted priority queue.
package spq_pkg;

	// Fixed field widths of the request and response beats.
	localparam int unsigned KEY_W   = 20;
	localparam int unsigned PAY_W   = 16;
	localparam int unsigned FILL_W  = 5;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned ERR_W   = 2;

	// Operation codes carried in the mode field.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Error codes reported with every result.
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] item_key;
		logic [PAY_W-1:0] item_payload;
	} spq_req_t;

	typedef struct packed {
		logic              out_valid;
		logic [KEY_W-1:0]  out_key;
		logic [PAY_W-1:0]  out_payload;
		logic [FILL_W-1:0] fill_count;
		logic [ERR_W-1:0]  error_code;
	} spq_rsp_t;

	// Shift commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_ctl_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// A request beat's response is registered in the output register when the beat is accepted.
// Throughput: one request per cycle unless stalled; every cell compares and shifts at once.
// The response register parts the sides, so a new request is taken as the response is taken.
// Reset clears the fill count and the response valid flag, and sets capacity to 16.
// Cell contents are not cleared; only cells below the fill count are ever read.
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
module sorted_priority_queue #(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned KEY_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  spq_pkg::spq_req_t         req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output spq_pkg::spq_rsp_t         rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [spq_pkg::CAP_W-1:0] cfg_data
);
	import spq_pkg::*;

	localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int unsigned AW   = (CMPW > FILL_W) ? CMPW : FILL_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;

	logic             acc;
	logic             is_ins;
	logic             is_rem;
	logic             full;
	logic             empty;
	logic [CMPW-1:0]  cap_ext;
	logic [CMPW-1:0]  eff_cap;
	logic [CMPW-1:0]  count_ext;
	logic [CW-1:0]    count_next;
	logic [AW-1:0]    fill_ext;
	logic [KEY_W-1:0] head_key;
	logic [KW-1:0]    new_key;
	spq_ctl_t         ctl;
	spq_rsp_t         rsp_next;

	logic [KW-1:0]    ck [DEPTH];
	logic [PAY_W-1:0] cp [DEPTH];
	logic             cg [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign new_key   = req.item_key[KW-1:0];

	// Capacity is limited to the number of cells.
	assign cap_ext   = CMPW'(cap_q);
	assign count_ext = CMPW'(count_q);
	assign eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
	assign full      = count_ext >= eff_cap;
	assign empty     = count_q == '0;
	assign is_ins    = acc && (req.mode == MODE_INSERT);
	assign is_rem    = acc && (req.mode == MODE_REMOVE);
	assign ctl.ins   = is_ins && !full;
	assign ctl.rem   = is_rem && !empty;

	// Chain of cells; the head sits at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             occ;
		logic             lgt;
		logic [KW-1:0]    lkey;
		logic [PAY_W-1:0] lpay;
		logic [KW-1:0]    rkey;
		logic [PAY_W-1:0] rpay;

		assign occ = CW'(i) < count_q;

		if (i == 0) begin : g_head
			assign lgt  = 1'b0;
			assign lkey = new_key;
			assign lpay = req.item_payload;
		end else begin : g_body
			assign lgt  = cg[i-1];
			assign lkey = ck[i-1];
			assign lpay = cp[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rkey = ck[i];
			assign rpay = cp[i];
		end else begin : g_inner
			assign rkey = ck[i+1];
			assign rpay = cp[i+1];
		end

		spq_cell #(
			.KW(KW)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.occ          (occ),
			.new_key      (new_key),
			.new_payload  (req.item_payload),
			.left_gt      (lgt),
			.left_key     (lkey),
			.left_payload (lpay),
			.right_key    (rkey),
			.right_payload(rpay),
			.key          (ck[i]),
			.payload      (cp[i]),
			.gt           (cg[i])
		);
	end

	// Next fill count and the response of the accepted beat.
	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CW'(1);
		end

		fill_ext = AW'(count_next);
		head_key = '0;
		head_key[KW-1:0] = ck[0];

		rsp_next             = '0;
		rsp_next.fill_count  = fill_ext[FILL_W-1:0];
		rsp_next.error_code  = ERR_OK;
		if (is_ins && full) begin
			rsp_next.error_code = ERR_FULL;
		end else if (is_rem && empty) begin
			rsp_next.error_code = ERR_EMPTY;
		end else if (is_rem) begin
			rsp_next.out_valid   = 1'b1;
			rsp_next.out_key     = head_key;
			rsp_next.out_payload = cp[0];
		end
	end

	// Control state: fill count, capacity and response handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_next;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload needs no reset.
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_next;
		end
	end

	// The fill count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("fill count above depth");

	// A successful insert grows the count by exactly one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the fill count");

	// A dropped insert leaves the fill count unchanged.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(is_ins && full) |=> $stable(count_q))
		else $error("dropped insert changed the fill count");

	// A returned entry never comes with an error code.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_valid) |-> (rsp.error_code == ERR_OK))
		else $error("returned entry flagged as error");

	// A held response stays unchanged while it waits.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("response changed while stalled");

endmodule

// ===== rtl/core/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry and compares it with the new key.
module spq_cell #(
	parameter int unsigned KW = 20
) (
	input  logic                      clk,
	input  spq_pkg::spq_ctl_t         ctl,
	input  logic                      occ,
	input  logic [KW-1:0]             new_key,
	input  logic [spq_pkg::PAY_W-1:0] new_payload,
	input  logic                      left_gt,
	input  logic [KW-1:0]             left_key,
	input  logic [spq_pkg::PAY_W-1:0] left_payload,
	input  logic [KW-1:0]             right_key,
	input  logic [spq_pkg::PAY_W-1:0] right_payload,
	output logic [KW-1:0]             key,
	output logic [spq_pkg::PAY_W-1:0] payload,
	output logic                      gt
);
	import spq_pkg::*;

	logic [KW-1:0]    key_q;
	logic [PAY_W-1:0] pay_q;

	// An empty cell behaves as if it held an infinitely large key.
	assign gt      = !occ || (key_q > new_key);
	assign key     = key_q;
	assign payload = pay_q;

	// On insert a cell whose key is larger moves one place back, taking either the
	// neighbour's entry or the new one; on removal every cell takes its right neighbour.
	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			if (left_gt) begin
				key_q <= left_key;
				pay_q <= left_payload;
			end else begin
				key_q <= new_key;
				pay_q <= new_payload;
			end
		end else if (ctl.rem) begin
			key_q <= right_key;
			pay_q <= right_payload;
		end
	end

endmodule
